FILE: rtl/assert_macros.svh
// Assertion macros shared by the stack RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge outside reset.
`define SWIM_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Check a property on every rising edge, reset included.
`define SWIM_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/swim_pkg.sv
// Types and codes of the stack with insert-after-match.
package swim_pkg;

    localparam int ACTION_W = 2;
    localparam int BYTE_W   = 8;
    localparam int STATUS_W = 2;
    localparam int FILL_W   = 5;

    // Action codes of an input word
    localparam logic [ACTION_W-1:0] ACT_PUSH   = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_INSERT = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_DUMP   = 2'd2;

    // Status codes of a result word
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOKEY = 2'd2;
    localparam logic [STATUS_W-1:0] ST_ELEM  = 2'd3;

    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic [BYTE_W-1:0]   value;
        logic [BYTE_W-1:0]   key;
    } t_in_word;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [BYTE_W-1:0]   data;
        logic [FILL_W-1:0]   fill;
        logic                last;
    } t_out_word;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic                wr_push;
        logic                wr_insert;
        logic                dump_start;
        logic                dump_step;
        logic                out_load;
        logic [STATUS_W-1:0] out_kind;
    } t_dp_cmd;

    // Status from the datapath to the controller
    typedef struct packed {
        logic full;
        logic found;
        logic empty;
        logic idx_last;
    } t_dp_stat;

endpackage

FILE: rtl/swim_if.sv
// Valid/ready channel interfaces for input and result words.
interface swim_in_if;
    import swim_pkg::*;

    logic     valid;
    logic     ready;
    t_in_word payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

interface swim_out_if;
    import swim_pkg::*;

    logic      valid;
    logic      ready;
    t_out_word payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

FILE: rtl/stack_with_insert_after_match.sv
// Top level of the bounded byte stack with push, insert-after-match and dump.
//
//  channel  | dir | word       | fields
//  i_in     | in  | t_in_word  | action, value, key
//  o_out    | out | t_out_word | status, data, fill, last
//
// For push and insert the result word is registered at the accepting edge.
// A dump of n entries first loads the dump index, then gives n words, one a cycle while
// o_out is taken; no new word is accepted until the bottom entry is loaded.
// An action that gives no result (unused code, dump of an empty stack) loads no result word.
// Synchronous active-low reset empties the stack; cell contents are not cleared.
// A stalled result holds the output register, and i_in waits until it is taken.
module stack_with_insert_after_match #(
    parameter int DEPTH = 16
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    swim_in_if.sink         i_in,
    swim_out_if.source      o_out
);
    import swim_pkg::*;

    t_dp_cmd   w_cmd;
    t_dp_stat  w_stat;
    t_out_word w_word;

    swim_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .i_action    (i_in.payload.action),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd)
    );

    swim_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_value (i_in.payload.value),
        .i_key   (i_in.payload.key),
        .i_cmd   (w_cmd),
        .o_stat  (w_stat),
        .o_word  (w_word)
    );

    assign o_out.payload = w_word;

endmodule

FILE: rtl/swim_dp.sv
// Datapath of the stack: storage cells, match search, fill count and result register.
`include "assert_macros.svh"

module swim_dp #(
    parameter int DEPTH = 16
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic [swim_pkg::BYTE_W-1:0] i_value,
    input  logic [swim_pkg::BYTE_W-1:0] i_key,
    input  swim_pkg::t_dp_cmd          i_cmd,
    output swim_pkg::t_dp_stat         o_stat,
    output swim_pkg::t_out_word        o_word
);
    import swim_pkg::*;

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int IDX_W = $clog2(DEPTH);
    localparam int LVLS  = $clog2(DEPTH);

    logic [BYTE_W-1:0]         r_cell [DEPTH];
    logic [BYTE_W-1:0]         n_cell [DEPTH];
    logic [CNT_W-1:0]          r_count;
    logic [CNT_W-1:0]          n_count;
    logic [CNT_W-1:0]          w_cnt_m1;
    logic [IDX_W-1:0]          r_idx;
    t_out_word                 r_word;
    logic [DEPTH-1:0]          w_match;
    logic [LVLS:0][DEPTH-1:0]  w_pre;
    logic [DEPTH-1:0]          w_excl;
    logic [DEPTH-1:0]          w_first;

    // Compare every occupied cell with the key
    always_comb begin
        for (int i = 0; i < DEPTH; i++) begin
            w_match[i] = (CNT_W'(i) < r_count) && (r_cell[i] == i_key);
        end
    end

    // Prefix OR of the matches in log steps
    always_comb begin
        w_pre[0] = w_match;
        for (int k = 0; k < LVLS; k++) begin
            for (int i = 0; i < DEPTH; i++) begin
                if (i >= (1 << k)) begin
                    w_pre[k+1][i] = w_pre[k][i] | w_pre[k][i - (1 << k)];
                end else begin
                    w_pre[k+1][i] = w_pre[k][i];
                end
            end
        end
    end

    // A match strictly below each cell, and the lowest match itself
    assign w_excl  = {w_pre[LVLS][DEPTH-2:0], 1'b0};
    assign w_first = w_match & ~w_excl;

    // Next cell contents for push and insert
    always_comb begin
        for (int i = 0; i < DEPTH; i++) begin
            n_cell[i] = r_cell[i];
        end
        if (i_cmd.wr_push) begin
            for (int i = 0; i < DEPTH; i++) begin
                if (CNT_W'(i) == r_count) begin
                    n_cell[i] = i_value;
                end
            end
        end
        if (i_cmd.wr_insert) begin
            for (int i = 1; i < DEPTH; i++) begin
                priority if (w_excl[i-1]) begin
                    n_cell[i] = r_cell[i-1];
                end else if (w_first[i-1]) begin
                    n_cell[i] = i_value;
                end else begin
                    n_cell[i] = r_cell[i];
                end
            end
        end
    end

    // Hold the cells; they need no reset
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < DEPTH; i++) begin
            r_cell[i] <= n_cell[i];
        end
    end

    assign n_count  = r_count + CNT_W'(i_cmd.wr_push || i_cmd.wr_insert);
    assign w_cnt_m1 = r_count - CNT_W'(1);

    // Advance the fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    // Walk the dump index from top to bottom
    always_ff @(posedge i_clk) begin
        if (i_cmd.dump_start) begin
            r_idx <= w_cnt_m1[IDX_W-1:0];
        end else if (i_cmd.dump_step) begin
            r_idx <= r_idx - IDX_W'(1);
        end
    end

    // Load the result word
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_word.status <= i_cmd.out_kind;
            r_word.data   <= (i_cmd.out_kind == ST_ELEM) ? r_cell[r_idx] : '0;
            r_word.fill   <= FILL_W'(n_count);
            r_word.last   <= (i_cmd.out_kind != ST_ELEM) || (r_idx == '0);
        end
    end

    assign o_stat.full     = (r_count == CNT_W'(DEPTH));
    assign o_stat.found    = w_pre[LVLS][DEPTH-1];
    assign o_stat.empty    = (r_count == '0);
    assign o_stat.idx_last = (r_idx == '0);
    assign o_word          = r_word;

    `SWIM_ASSERT(a_count_bound, i_clk, i_rst_n,
        r_count <= CNT_W'(DEPTH), "fill above depth")
    `SWIM_ASSERT(a_push_grows, i_clk, i_rst_n,
        i_cmd.wr_push |=> (r_count == CNT_W'($past(r_count) + 1'b1)),
        "push did not grow the stack")
    `SWIM_ASSERT(a_insert_found, i_clk, i_rst_n,
        i_cmd.wr_insert |-> (o_stat.found && !o_stat.full),
        "insert without a free slot and a match")

endmodule

FILE: rtl/swim_ctrl.sv
// Controller of the stack: action decode, dump sequencing and result valid.
`include "assert_macros.svh"

module swim_ctrl (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic [swim_pkg::ACTION_W-1:0] i_action,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    input  swim_pkg::t_dp_stat           i_stat,
    output swim_pkg::t_dp_cmd            o_cmd
);
    import swim_pkg::*;

    localparam logic [0:0] S_IDLE = 1'b0;
    localparam logic [0:0] S_DUMP = 1'b1;

    logic [0:0] r_state;
    logic [0:0] n_state;
    logic       r_out_valid;
    logic       w_out_free;
    logic       w_accept;
    t_dp_cmd    w_cmd;

    assign w_out_free = !r_out_valid || i_out_ready;
    assign o_in_ready = i_rst_n && (r_state == S_IDLE) && w_out_free;
    assign w_accept   = i_in_valid && o_in_ready;

    // Decode the accepted word and step the dump
    always_comb begin
        w_cmd   = '0;
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    unique case (i_action)
                        ACT_PUSH: begin
                            w_cmd.out_load = 1'b1;
                            if (i_stat.full) begin
                                w_cmd.out_kind = ST_FULL;
                            end else begin
                                w_cmd.out_kind = ST_OK;
                                w_cmd.wr_push  = 1'b1;
                            end
                        end
                        ACT_INSERT: begin
                            w_cmd.out_load = 1'b1;
                            priority if (i_stat.full) begin
                                w_cmd.out_kind = ST_FULL;
                            end else if (i_stat.found) begin
                                w_cmd.out_kind  = ST_OK;
                                w_cmd.wr_insert = 1'b1;
                            end else begin
                                w_cmd.out_kind = ST_NOKEY;
                            end
                        end
                        ACT_DUMP: begin
                            if (!i_stat.empty) begin
                                w_cmd.dump_start = 1'b1;
                                n_state          = S_DUMP;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_DUMP: begin
                if (w_out_free) begin
                    w_cmd.out_load  = 1'b1;
                    w_cmd.out_kind  = ST_ELEM;
                    w_cmd.dump_step = 1'b1;
                    if (i_stat.idx_last) begin
                        n_state = S_IDLE;
                    end
                end
            end
        endcase
    end

    // Advance the state and hold the result valid until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_cmd       = w_cmd;
    assign o_out_valid = r_out_valid;

    `SWIM_ASSERT(a_dump_end, i_clk, i_rst_n, ((r_state == S_DUMP) ##1 (r_state == S_IDLE)) |-> $past(w_cmd.out_load && i_stat.idx_last), "dump left before the bottom word")
    `SWIM_ASSERT(a_one_op, i_clk, i_rst_n, $onehot0({w_cmd.wr_push, w_cmd.wr_insert, w_cmd.dump_start}), "more than one operation at once")
    `SWIM_ASSERT(a_no_overwrite, i_clk, i_rst_n, (r_out_valid && !i_out_ready) |-> !w_cmd.out_load, "result word overwritten before taken")

endmodule

FILE: tb/stack_with_insert_after_match_tb.sv
// Self-checking testbench of the byte stack with push, insert-after-match and dump.
`timescale 1ns / 100ps

module stack_with_insert_after_match_tb;
    import swim_pkg::*;

    localparam int DEPTH = 16;
    localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;
    localparam int HOLD_CYCLES = 300;
    localparam int QUIET_LIMIT = 20000;

    logic i_clk = 1'b0;
    logic i_rst_n;

    swim_in_if  in_ch ();
    swim_out_if out_ch ();

    stack_with_insert_after_match #(
        .DEPTH (DEPTH)
    ) u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    // Clock
    always #5 i_clk = ~i_clk;

    // Stack contents as the testbench expects them
    logic [BYTE_W-1:0] stack_bytes [DEPTH];
    int                stack_fill = 0;

    t_in_word  pending_words [$];
    t_out_word expected_words [$];
    logic [BYTE_W-1:0] stored_vals [$];

    int  issued_cnt    = 0;
    int  accepted_cnt  = 0;
    int  fail_cnt      = 0;
    int  send_idle_pct = 0;
    int  recv_idle_pct = 0;
    bit  in_taken      = 1'b0;
    bit  hold_req      = 1'b0;
    bit  hold_done     = 1'b0;
    int  hold_left     = 0;

    // Queue one result word with the current fill level
    function automatic void expect_word(logic [STATUS_W-1:0] status, logic [BYTE_W-1:0] data,
                                        logic last);
        t_out_word w;
        w.status = status;
        w.data   = data;
        w.fill   = FILL_W'(stack_fill);
        w.last   = last;
        expected_words.push_back(w);
    endfunction

    // Advance the expected stack by one accepted word and queue its results
    function automatic void stack_apply(t_in_word w);
        int hit;
        hit = -1;
        case (w.action)
            ACT_PUSH: begin
                if (stack_fill < DEPTH) begin
                    stack_bytes[stack_fill] = w.value;
                    stack_fill++;
                    expect_word(ST_OK, '0, 1'b1);
                end else begin
                    expect_word(ST_FULL, '0, 1'b1);
                end
            end
            ACT_INSERT: begin
                // full test comes before the key search
                if (stack_fill >= DEPTH) begin
                    expect_word(ST_FULL, '0, 1'b1);
                end else begin
                    for (int i = 0; i < stack_fill; i++) begin
                        if (hit < 0 && stack_bytes[i] == w.key)
                            hit = i;
                    end
                    if (hit < 0) begin
                        expect_word(ST_NOKEY, '0, 1'b1);
                    end else begin
                        for (int j = stack_fill; j > hit + 1; j--)
                            stack_bytes[j] = stack_bytes[j-1];
                        stack_bytes[hit+1] = w.value;
                        stack_fill++;
                        expect_word(ST_OK, '0, 1'b1);
                    end
                end
            end
            ACT_DUMP: begin
                // top to bottom; an empty stack gives nothing
                for (int i = stack_fill; i > 0; i--)
                    expect_word(ST_ELEM, stack_bytes[i-1], i == 1);
            end
            default: ;
        endcase
    endfunction

    // Check result words and record accepted input words
    always @(posedge i_clk) begin
        t_out_word got;
        t_out_word exp_w;
        in_taken = 1'b0;
        if (i_rst_n) begin
            if (out_ch.valid && out_ch.ready) begin
                got = out_ch.payload;
                if (expected_words.size() == 0) begin
                    fail_cnt++;
                    if (fail_cnt <= 10)
                        $display("ERROR: unexpected word status=%0d data=%0d fill=%0d last=%0d",
                                 got.status, got.data, got.fill, got.last);
                end else begin
                    exp_w = expected_words.pop_front();
                    if (got.status !== exp_w.status || got.data !== exp_w.data ||
                        got.fill !== exp_w.fill || got.last !== exp_w.last) begin
                        fail_cnt++;
                        if (fail_cnt <= 10) begin
                            $display("ERROR: expected status=%0d data=%0d fill=%0d last=%0d",
                                     exp_w.status, exp_w.data, exp_w.fill, exp_w.last);
                            $display("       got      status=%0d data=%0d fill=%0d last=%0d",
                                     got.status, got.data, got.fill, got.last);
                        end
                    end
                end
            end
            if (in_ch.valid && in_ch.ready) begin
                in_taken = 1'b1;
                accepted_cnt++;
                stack_apply(in_ch.payload);
            end
        end
    end

    // Drive input words, holding each until it is taken
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
        end else if (in_ch.valid && !in_taken) begin
            // hold the current word
        end else if (pending_words.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
            in_ch.payload <= pending_words.pop_front();
            in_ch.valid   <= 1'b1;
        end else begin
            in_ch.valid <= 1'b0;
        end
    end

    // Drive result ready, with random stalls and one long hold-off
    always @(negedge i_clk) begin
        if (hold_req && !hold_done) begin
            hold_left = HOLD_CYCLES;
            hold_done = 1'b1;
        end
        if (hold_left > 0) begin
            hold_left--;
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    function automatic void add_word(logic [ACTION_W-1:0] action, logic [BYTE_W-1:0] value,
                                     logic [BYTE_W-1:0] key);
        pending_words.push_back('{action: action, value: value, key: key});
        issued_cnt++;
        if (action == ACT_PUSH || action == ACT_INSERT)
            stored_vals.push_back(value);
    endfunction

    // Random words: pushes, inserts, dumps and unused codes; keys are mostly values that were stored
    function automatic void add_random_words(int n);
        int                 pick;
        logic [ACTION_W-1:0] action;
        logic [BYTE_W-1:0]   key;
        for (int k = 0; k < n; k++) begin
            pick = $urandom_range(99);
            if (pick < 15)      action = ACT_PUSH;
            else if (pick < 60) action = ACT_INSERT;
            else if (pick < 90) action = ACT_DUMP;
            else                action = ACT_UNUSED;
            if (stored_vals.size() > 0 && $urandom_range(2) != 0)
                key = stored_vals[$urandom_range(stored_vals.size() - 1)];
            else
                key = BYTE_W'($urandom_range(255));
            add_word(action, BYTE_W'($urandom_range(255)), key);
        end
    endfunction

    // Wait until every word is taken and every result has arrived
    task automatic wait_quiet();
        int guard;
        guard = 0;
        while ((accepted_cnt != issued_cnt || expected_words.size() != 0) &&
               guard < QUIET_LIMIT) begin
            @(negedge i_clk);
            guard++;
        end
    endtask

    // Stimulus
    initial begin
        i_rst_n       = 1'b0;
        in_ch.valid   = 1'b0;
        in_ch.payload = '0;
        out_ch.ready  = 1'b0;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        @(posedge i_clk);
        send_idle_pct = 10;
        recv_idle_pct = 49;

        // dump and unused code on an empty stack, insert with nothing stored
        add_word(ACT_DUMP,   8'h00, 8'h00);
        add_word(ACT_UNUSED, 8'h00, 8'h00);
        add_word(ACT_INSERT, 8'h11, 8'h00);
        // duplicate keys: the insert follows the lowest match
        add_word(ACT_PUSH,   8'h00, 8'hFF);
        add_word(ACT_PUSH,   8'hFF, 8'h00);
        add_word(ACT_PUSH,   8'h00, 8'h00);
        add_word(ACT_INSERT, 8'hA5, 8'h00);
        add_word(ACT_INSERT, 8'h5A, 8'hFF);
        add_word(ACT_INSERT, 8'h77, 8'h77);
        // insert just above the top entry, nothing to shift
        add_word(ACT_PUSH,   8'h3C, 8'h00);
        add_word(ACT_INSERT, 8'hC3, 8'h3C);
        add_word(ACT_DUMP,   8'hFF, 8'hFF);
        add_word(ACT_UNUSED, 8'hFF, 8'hFF);
        add_random_words(45);
        wait_quiet();

        // swap idling, block the receiver while the sender keeps offering
        @(posedge i_clk);
        send_idle_pct = 49;
        recv_idle_pct = 10;
        hold_req      = 1'b1;
        add_random_words(45);
        wait_quiet();

        // no idling on either side
        @(posedge i_clk);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        add_random_words(45);
        wait_quiet();
        repeat (20) @(negedge i_clk);

        if (accepted_cnt != issued_cnt || expected_words.size() != 0) begin
            fail_cnt++;
            $display("ERROR: %0d words not taken, %0d results never arrived",
                     issued_cnt - accepted_cnt, expected_words.size());
        end
        if (fail_cnt == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    // Watchdog
    initial begin
        #5_000_000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule
